// ----- design/scba_pkg.sv -----
// shared types, constants and class geometry for the size-class block allocator
// used by scba_link_mem, scba_stats and size_class_block_allocator
package scba_pkg;

    localparam int CLASS_MAX       = 8;
    localparam int NUM_CLASSES_DEF = 8;
    localparam int CLS_W           = 3;
    localparam int IDX_W           = 8;
    localparam int CNT_W           = 9;
    localparam int ADDR_W          = 9;
    localparam int STORE_DEPTH     = 512;
    localparam int BYTES_W         = 12;
    localparam int USAGE_W         = 16;
    localparam int TOTAL_W         = 64;
    localparam int LIVE_W          = 9;
    localparam int LINK_W          = IDX_W + 1;   // {in-use mark, next link}

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 192;
    localparam int STAT_W   = 3;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BAD_CLASS = 3'd4;
    localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 3'd5;
    localparam logic [STAT_W-1:0] STAT_DOUBLE    = 3'd6;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic               upd;
        logic               is_free;
        logic [BYTES_W-1:0] bytes;
    } stats_cmd_t;

    typedef struct packed {
        logic [USAGE_W-1:0] usage;
        logic [USAGE_W-1:0] peak;
        logic [TOTAL_W-1:0] alloc_total;
        logic [TOTAL_W-1:0] freed_total;
        logic [LIVE_W-1:0]  live;
    } stats_view_t;

    // block size in bytes: 16 << c
    function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
        return 12'd16 << c;
    endfunction

    // blocks held by a class: 256 >> c
    function automatic logic [CNT_W-1:0] class_blocks(input logic [CLS_W-1:0] c);
        return 9'd256 >> c;
    endfunction

    // first store entry of a class: 512 - (512 >> c)
    function automatic logic [ADDR_W-1:0] class_base(input logic [CLS_W-1:0] c);
        logic [ADDR_W:0] full;
        full = 10'd512 - (10'd512 >> c);
        return full[ADDR_W-1:0];
    endfunction

    // class that owns a store entry
    function automatic logic [CLS_W-1:0] addr_class(input logic [ADDR_W-1:0] addr);
        logic [CLS_W-1:0] cls;
        cls = '0;
        for (int c = 0; c < CLASS_MAX; c++) begin
            if (addr >= class_base(CLS_W'(c))) begin
                cls = CLS_W'(c);
            end
        end
        return cls;
    endfunction

endpackage

// ----- design/scba_link_mem.sv -----
// link store: per-block {in-use mark, next free link}, one write and one read port
// depends on scba_pkg for widths and depth
module scba_link_mem (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [scba_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [scba_pkg::LINK_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [scba_pkg::ADDR_W-1:0]   rd_addr,
    output logic [scba_pkg::LINK_W-1:0]   rd_data
);
    import scba_pkg::*;

    logic [LINK_W-1:0] mem [STORE_DEPTH];
    logic [LINK_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/scba_stats.sv -----
// usage statistics with one shared 64-bit accumulate adder for both byte totals
// depends on scba_pkg for stats_cmd_t and stats_view_t
module scba_stats (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  scba_pkg::stats_cmd_t    cmd,
    output scba_pkg::stats_view_t   view
);
    import scba_pkg::*;

    logic [USAGE_W-1:0] usage_reg, usage_next;
    logic [USAGE_W-1:0] peak_reg, peak_next;
    logic [TOTAL_W-1:0] alloc_reg, alloc_next;
    logic [TOTAL_W-1:0] freed_reg, freed_next;
    logic [LIVE_W-1:0]  live_reg, live_next;
    logic [TOTAL_W-1:0] acc_sum;

    // shared adder: operand picked by request kind
    assign acc_sum = (cmd.is_free ? freed_reg : alloc_reg) + TOTAL_W'(cmd.bytes);

    always_comb begin
        usage_next = usage_reg;
        alloc_next = alloc_reg;
        freed_next = freed_reg;
        live_next  = live_reg;
        if (cmd.upd) begin
            if (cmd.is_free) begin
                freed_next = acc_sum;
                usage_next = usage_reg - USAGE_W'(cmd.bytes);
                live_next  = live_reg - LIVE_W'(1);
            end else begin
                alloc_next = acc_sum;
                usage_next = usage_reg + USAGE_W'(cmd.bytes);
                live_next  = live_reg + LIVE_W'(1);
            end
        end
        // peak is compared against the registered usage, not against usage_next
        peak_next = (usage_reg > peak_reg) ? usage_reg : peak_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            usage_reg <= '0;
            peak_reg  <= '0;
            alloc_reg <= '0;
            freed_reg <= '0;
            live_reg  <= '0;
        end else begin
            usage_reg <= usage_next;
            peak_reg  <= peak_next;
            alloc_reg <= alloc_next;
            freed_reg <= freed_next;
            live_reg  <= live_next;
        end
    end

    assign view.usage       = usage_reg;
    assign view.peak        = peak_next;
    assign view.alloc_total = alloc_reg;
    assign view.freed_total = freed_reg;
    assign view.live        = live_reg;

endmodule

// ----- design/size_class_block_allocator.sv -----
// top level of the size-class block allocator: request sequencer, list heads and counts
// depends on scba_pkg, scba_link_mem and scba_stats
//
// usage:
//   the slave channel takes one request per transfer: s_tuser is the kind
//   (allocate or free), s_tdata carries the size and the handle to free.
//   the master channel returns one result per request: m_tuser is the
//   status, m_tdata the handle, the class free count and the statistics.
//   each request runs through a small sequencer: decode (class pick and
//   link store read), update (store write, list and statistics update in
//   the shared accumulate unit) and finish (result register load). a request
//   that decode rejects skips update and goes straight to finish. one request
//   is in flight at a time, so a new one is taken only after the last has left
//   finish; the link store read comes in decode, before the list pop or push
//   in update. after reset the block sweeps the 512-entry link store to
//   build the free chains and clear the in-use marks: s_tready stays low
//   until the sweep is done. a result waiting on a stalled receiver does
//   not block the next request transfer; that request waits in finish
//   until m_tready frees the result register.
module size_class_block_allocator #(
    parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [scba_pkg::S_DATA_W-1:0] s_tdata,   // request_size, free_class, free_index
    input  logic                          s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // granted_class, granted_index, class_free_count, bytes in use, peak bytes in use,
    // bytes allocated, bytes freed, blocks_in_use, zero pad
    output logic [scba_pkg::M_DATA_W-1:0] m_tdata,
    output logic [scba_pkg::STAT_W-1:0]   m_tuser    // status
);
    import scba_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;

    // accepted request
    logic               kind_reg;
    logic [31:0]        size_reg;
    logic [7:0]         fc_reg;
    logic [IDX_W-1:0]   fi_reg;

    // decoded request
    logic [CLS_W-1:0]   cls_reg;
    logic [ADDR_W-1:0]  slot_reg;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [IDX_W-1:0]   gidx_reg, gidx_next;
    logic [CNT_W-1:0]   gfree_reg, gfree_next;

    // per-class list state
    logic [IDX_W-1:0]   head_reg [CLASS_MAX];
    logic [CNT_W-1:0]   cnt_reg  [CLASS_MAX];

    logic [ADDR_W-1:0]  clr_addr_reg;

    // result register
    logic                out_valid_reg;
    logic [STAT_W-1:0]   out_status_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    // decode
    logic               fit_found;
    logic [CLS_W-1:0]   fit_cls;
    logic [STAT_W-1:0]  dec_status;
    logic [CLS_W-1:0]   dec_cls;
    logic [IDX_W-1:0]   dec_gidx;
    logic [CNT_W-1:0]   dec_gfree;
    logic               dec_go;
    logic [ADDR_W-1:0]  dec_addr;

    // link store
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [LINK_W-1:0]  mem_wr_data;
    logic               mem_rd_en;
    logic [LINK_W-1:0]  mem_rd_data;
    logic               rd_mark;
    logic [IDX_W-1:0]   rd_link;

    logic [CLS_W-1:0]   clr_cls;
    logic [CNT_W-1:0]   clr_mask;
    logic [ADDR_W-1:0]  clr_inc;

    stats_cmd_t         st_cmd;
    stats_view_t        st_view;

    logic               accept;
    logic               out_free;
    logic               upd_ok;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign rd_mark = mem_rd_data[LINK_W-1];
    assign rd_link = mem_rd_data[IDX_W-1:0];

    // smallest enabled class that fits, compares run side by side
    always_comb begin
        fit_found = 1'b0;
        fit_cls   = '0;
        for (int c = CLASS_MAX - 1; c >= 0; c--) begin
            if (c < NUM_CLASSES && size_reg <= 32'(class_bytes(CLS_W'(c)))) begin
                fit_found = 1'b1;
                fit_cls   = CLS_W'(c);
            end
        end
    end

    always_comb begin
        dec_status = STAT_OK;
        dec_cls    = '0;
        dec_gidx   = '0;
        dec_gfree  = '0;
        dec_go     = 1'b0;
        dec_addr   = '0;
        if (kind_reg == KIND_ALLOC) begin
            priority if (size_reg == 32'd0) begin
                dec_status = STAT_ZERO;
            end else if (!fit_found) begin
                dec_status = STAT_TOO_LARGE;
            end else if (cnt_reg[fit_cls] == '0) begin
                dec_status = STAT_EXHAUSTED;
                dec_cls    = fit_cls;
            end else begin
                dec_cls  = fit_cls;
                dec_gidx = head_reg[fit_cls];
                dec_go   = 1'b1;
                dec_addr = class_base(fit_cls) + ADDR_W'(head_reg[fit_cls]);
            end
        end else begin
            priority if (32'(fc_reg) >= 32'(NUM_CLASSES)) begin
                dec_status = STAT_BAD_CLASS;
            end else if (CNT_W'(fi_reg) >= class_blocks(fc_reg[CLS_W-1:0])) begin
                dec_status = STAT_BAD_INDEX;
                dec_cls    = fc_reg[CLS_W-1:0];
                dec_gidx   = fi_reg;
                dec_gfree  = cnt_reg[fc_reg[CLS_W-1:0]];
            end else begin
                dec_cls  = fc_reg[CLS_W-1:0];
                dec_gidx = fi_reg;
                dec_go   = 1'b1;
                dec_addr = class_base(fc_reg[CLS_W-1:0]) + ADDR_W'(fi_reg);
            end
        end
    end

    // reset chain: each entry links to the next index of its class, the last wraps to 0
    assign clr_cls  = addr_class(clr_addr_reg);
    assign clr_mask = class_blocks(clr_cls) - CNT_W'(1);
    assign clr_inc  = clr_addr_reg + ADDR_W'(1);

    // a free of a block not marked in use changes nothing
    assign upd_ok = (state_reg == S_UPDATE) && (kind_reg == KIND_ALLOC || rd_mark);

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = slot_reg;
        mem_wr_data = '0;
        if (state_reg == S_CLEAR) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = {1'b0, clr_inc[IDX_W-1:0] & clr_mask[IDX_W-1:0]};
        end else if (upd_ok) begin
            mem_wr_en = 1'b1;
            if (kind_reg == KIND_ALLOC) begin
                mem_wr_data = {1'b1, rd_link};
            end else begin
                mem_wr_data = {1'b0, head_reg[cls_reg]};
            end
        end
    end

    assign mem_rd_en = (state_reg == S_DECODE) && dec_go;

    assign st_cmd.upd     = upd_ok;
    assign st_cmd.is_free = kind_reg;
    assign st_cmd.bytes   = class_bytes(cls_reg);

    always_comb begin
        status_next = status_reg;
        gidx_next   = gidx_reg;
        gfree_next  = gfree_reg;
        if (state_reg == S_DECODE) begin
            status_next = dec_status;
            gidx_next   = dec_gidx;
            gfree_next  = dec_gfree;
        end else if (state_reg == S_UPDATE) begin
            if (kind_reg == KIND_ALLOC) begin
                gfree_next = cnt_reg[cls_reg] - CNT_W'(1);
            end else if (rd_mark) begin
                gfree_next = cnt_reg[cls_reg] + CNT_W'(1);
            end else begin
                status_next = STAT_DOUBLE;
                gfree_next  = cnt_reg[cls_reg];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = dec_go ? S_UPDATE : S_FINISH;
            end
            S_UPDATE: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer and list state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            for (int c = 0; c < CLASS_MAX; c++) begin
                head_reg[c] <= '0;
                cnt_reg[c]  <= class_blocks(CLS_W'(c));
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_addr_reg <= clr_inc;
            end
            if (upd_ok) begin
                if (kind_reg == KIND_ALLOC) begin
                    head_reg[cls_reg] <= rd_link;
                    cnt_reg[cls_reg]  <= cnt_reg[cls_reg] - CNT_W'(1);
                end else begin
                    head_reg[cls_reg] <= fi_reg;
                    cnt_reg[cls_reg]  <= cnt_reg[cls_reg] + CNT_W'(1);
                end
            end
        end
    end

    // request payload and decode results
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser;
            size_reg <= s_tdata[31:0];
            fc_reg   <= s_tdata[39:32];
            fi_reg   <= s_tdata[47:40];
        end
        if (state_reg == S_DECODE) begin
            cls_reg  <= dec_cls;
            slot_reg <= dec_addr;
        end
        status_reg <= status_next;
        gidx_reg   <= gidx_next;
        gfree_reg  <= gfree_next;
    end

    // result register, holds while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == S_FINISH && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FINISH && out_free) begin
            out_status_reg <= status_reg;
            out_data_reg   <= {3'b000, st_view.live, st_view.freed_total,
                               st_view.alloc_total, st_view.peak, st_view.usage,
                               gfree_reg, gidx_reg, cls_reg};
        end
    end

    // cls_reg is loaded in decode for every request, so a request that decode rejects early
    // carries the class that decode gave it, never one left over from an earlier request
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_data_reg;

    scba_link_mem u_link_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (dec_addr),
        .rd_data (mem_rd_data)
    );

    scba_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (st_cmd),
        .view    (st_view)
    );

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for size_class_block_allocator: drives allocate and free requests
// and checks every result against a built-in model of the free lists and usage statistics
// depends on scba_pkg and the size_class_block_allocator rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scba_pkg::*;

    localparam int N_CLS      = NUM_CLASSES_DEF;
    localparam int N_RANDOM   = 1700;
    localparam int CYCLE_CAP  = 400000;  // clearing sweep plus slowest stalls, several times over
    localparam int DRAIN_WAIT = 40;      // settling margin after the last result is seen

    // one request as it travels on the slave channel
    typedef struct packed {
        logic        kind;
        logic [31:0] size;
        logic [7:0]  fcls;
        logic [7:0]  fidx;
    } alloc_req_t;

    // one result as it travels on the master channel
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [2:0]         cls;
        logic [7:0]         idx;
        logic [8:0]         free_cnt;
        logic [15:0]        usage;
        logic [15:0]        peak;
        logic [63:0]        alloc_total;
        logic [63:0]        freed_total;
        logic [8:0]         live;
    } alloc_resp_t;

    // a handle currently held by the testbench
    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] idx;
    } handle_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]   m_tuser;

    size_class_block_allocator #(
        .NUM_CLASSES(N_CLS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // request_size, free_class, free_index
        .s_tuser  (s_tuser),    // kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // granted_class .. blocks_in_use, zero pad
        .m_tuser  (m_tuser)     // status
    );

    // ------------------------------------------------------------------
    // model of the pool: link store, in-use marks, list heads, counts, stats
    // ------------------------------------------------------------------
    logic [8:0]  pool_link [512];
    logic        pool_mark [512];
    logic [8:0]  pool_head [8];
    logic [8:0]  pool_free [8];
    logic [15:0] usage_now;
    logic [15:0] usage_peak;
    logic [63:0] alloc_sum;
    logic [63:0] freed_sum;
    logic [8:0]  live_cnt;

    handle_t     held_q[$];      // handles that the model says are allocated
    alloc_req_t  req_q[$];       // requests waiting for the driver
    alloc_resp_t resp_due_q[$];  // results predicted but not yet seen

    alloc_req_t  req_on_bus;
    int          err_cnt = 0;
    int          cyc_cnt = 0;
    int          idle_stage = 0;  // 0: sender 22 / receiver 83, 1: swapped, 2: no idling

    // class geometry, kept as plain tables
    function automatic int blk_bytes(input int c);
        case (c)
            0: return 16;
            1: return 32;
            2: return 64;
            3: return 128;
            4: return 256;
            5: return 512;
            6: return 1024;
            default: return 2048;
        endcase
    endfunction

    function automatic int blk_count(input int c);
        case (c)
            0: return 256;
            1: return 128;
            2: return 64;
            3: return 32;
            4: return 16;
            5: return 8;
            6: return 4;
            default: return 2;
        endcase
    endfunction

    function automatic int blk_base(input int c);
        case (c)
            0: return 0;
            1: return 256;
            2: return 384;
            3: return 448;
            4: return 480;
            5: return 496;
            6: return 504;
            default: return 508;
        endcase
    endfunction

    // every class starts as an ascending chain, nothing in use
    task automatic pool_clear();
        for (int s = 0; s < 512; s++) begin
            pool_link[s] = '0;
            pool_mark[s] = 1'b0;
        end
        for (int c = 0; c < 8; c++) begin
            for (int i = 0; i + 1 < blk_count(c); i++) begin
                pool_link[blk_base(c) + i] = 9'(i + 1);
            end
            pool_head[c] = '0;
            pool_free[c] = 9'(blk_count(c));
        end
        usage_now  = '0;
        usage_peak = '0;
        alloc_sum  = '0;
        freed_sum  = '0;
        live_cnt   = '0;
        held_q.delete();
    endtask

    // apply one request to the model and return the result it should produce
    function automatic alloc_resp_t pool_step(input alloc_req_t r);
        alloc_resp_t rs;
        int          c;
        int          slot;
        int          blk;
        handle_t     h;
        rs = '0;
        if (r.kind == KIND_ALLOC) begin
            if (r.size == 32'd0) begin
                rs.status = STAT_ZERO;
            end else begin
                // smallest class that fits
                c = N_CLS;
                for (int k = N_CLS - 1; k >= 0; k--) begin
                    if (r.size <= 32'(blk_bytes(k))) c = k;
                end
                if (c >= N_CLS) begin
                    rs.status = STAT_TOO_LARGE;
                end else if (pool_free[c] == 0) begin
                    rs.status = STAT_EXHAUSTED;
                    rs.cls    = 3'(c);
                end else begin
                    // pop the head of the class list
                    blk          = int'(pool_head[c]) % blk_count(c);
                    slot         = blk_base(c) + blk;
                    pool_head[c] = 9'(int'(pool_link[slot]) % blk_count(c));
                    pool_free[c] = pool_free[c] - 9'd1;
                    pool_mark[slot] = 1'b1;
                    live_cnt  = live_cnt + 9'd1;
                    alloc_sum = alloc_sum + 64'(blk_bytes(c));
                    usage_now = usage_now + 16'(blk_bytes(c));
                    if (usage_now > usage_peak) usage_peak = usage_now;
                    rs.cls      = 3'(c);
                    rs.idx      = 8'(blk);
                    rs.free_cnt = pool_free[c];
                    h.cls = 3'(c);
                    h.idx = 8'(blk);
                    held_q.push_back(h);
                end
            end
        end else begin
            if (int'(r.fcls) >= N_CLS) begin
                rs.status = STAT_BAD_CLASS;
            end else begin
                c = int'(r.fcls);
                rs.cls = 3'(c);
                rs.idx = r.fidx;
                if (int'(r.fidx) >= blk_count(c)) begin
                    rs.status = STAT_BAD_INDEX;
                end else begin
                    slot = blk_base(c) + int'(r.fidx);
                    if (!pool_mark[slot]) begin
                        rs.status = STAT_DOUBLE;
                    end else begin
                        // push the block back as the new head
                        pool_mark[slot] = 1'b0;
                        pool_link[slot] = pool_head[c];
                        pool_head[c]    = {1'b0, r.fidx};
                        pool_free[c]    = pool_free[c] + 9'd1;
                        live_cnt  = live_cnt - 9'd1;
                        freed_sum = freed_sum + 64'(blk_bytes(c));
                        usage_now = usage_now - 16'(blk_bytes(c));
                        for (int k = 0; k < held_q.size(); k++) begin
                            if (held_q[k].cls == 3'(c) && held_q[k].idx == r.fidx) begin
                                held_q.delete(k);
                                break;
                            end
                        end
                    end
                end
                rs.free_cnt = pool_free[c];
            end
        end
        // statistics as they stand after the step, whatever the status
        rs.usage       = usage_now;
        rs.peak        = usage_peak;
        rs.alloc_total = alloc_sum;
        rs.freed_total = freed_sum;
        rs.live        = live_cnt;
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        pool_clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // idle share in percent for each side, by stage
    function automatic int tx_idle_pct();
        return (idle_stage == 0) ? 22 : (idle_stage == 1) ? 83 : 0;
    endfunction

    function automatic int rx_idle_pct();
        return (idle_stage == 0) ? 83 : (idle_stage == 1) ? 22 : 0;
    endfunction

    // ------------------------------------------------------------------
    // driver: the model is stepped at the edge where the transfer happens,
    // then the next request (if any, and if not idling) goes on the bus
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drv
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                resp_due_q.push_back(pool_step(req_on_bus));
            end
            // the slot is free when nothing waits on the bus or it just went
            if (!s_tvalid || s_tready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
                    req_on_bus = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_W'({req_on_bus.fidx, req_on_bus.fcls, req_on_bus.size});
                    s_tuser  <= req_on_bus.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: each result transfer is checked against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : mon
        alloc_resp_t got;
        alloc_resp_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status      = m_tuser;
                got.cls         = m_tdata[2:0];
                got.idx         = m_tdata[10:3];
                got.free_cnt    = m_tdata[19:11];
                got.usage       = m_tdata[35:20];
                got.peak        = m_tdata[51:36];
                got.alloc_total = m_tdata[115:52];
                got.freed_total = m_tdata[179:116];
                got.live        = m_tdata[188:180];
                if (resp_due_q.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10) begin
                        $display("%0t: result with no request pending:", $realtime);
                        $display("  status %0d class %0d idx %0d",
                                 got.status, got.cls, got.idx);
                    end
                end else begin
                    want = resp_due_q.pop_front();
                    if (got !== want) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= 10) begin
                            $display("%0t: result differs (exp / got)", $realtime);
                            $display("  status %0d / %0d  class %0d / %0d",
                                     want.status, got.status, want.cls, got.cls);
                            $display("  idx %0d / %0d  free %0d / %0d",
                                     want.idx, got.idx, want.free_cnt, got.free_cnt);
                            $display("  usage %0d / %0d  peak %0d / %0d  live %0d / %0d",
                                     want.usage, got.usage, want.peak, got.peak,
                                     want.live, got.live);
                            $display("  alloc %h / %h  freed %h / %h",
                                     want.alloc_total, got.alloc_total,
                                     want.freed_total, got.freed_total);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct());
        end
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cyc_cnt = cyc_cnt + 1;
        if (cyc_cnt > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // hand one request to the driver; refilled at the falling edge so the
    // driver always finds the next one ready when a transfer completes
    task automatic send_req(input alloc_req_t r);
        do @(negedge aclk); while (req_q.size() != 0);
        req_q.push_back(r);
    endtask

    // unused handle fields carry random noise
    function automatic alloc_req_t mk_alloc(input logic [31:0] size);
        alloc_req_t r;
        r.kind = KIND_ALLOC;
        r.size = size;
        r.fcls = 8'($urandom);
        r.fidx = 8'($urandom);
        return r;
    endfunction

    // the ignored size field carries random noise
    function automatic alloc_req_t mk_free(input logic [7:0] c, input logic [7:0] i);
        alloc_req_t r;
        r.kind = KIND_FREE;
        r.size = $urandom;
        r.fcls = c;
        r.fidx = i;
        return r;
    endfunction

    // a size that lands in class c, anywhere inside its range
    function automatic logic [31:0] size_in_class(input int c);
        int lo;
        lo = (c == 0) ? 1 : blk_bytes(c) / 2 + 1;
        return 32'($urandom_range(blk_bytes(c), lo));
    endfunction

    initial begin : gen
        int      alloc_pct;
        int      free_pct;
        int      dice;
        int      c;
        handle_t h;

        // directed: size edges, every status, lifo reuse
        send_req(mk_alloc(32'd0));            // zero size
        send_req(mk_alloc(32'd1));            // smallest class, index 0
        send_req(mk_alloc(32'd16));           // exact fit of class 0
        send_req(mk_alloc(32'd17));           // one over goes to class 1
        send_req(mk_alloc(32'd2048));         // largest class
        send_req(mk_alloc(32'd2049));         // too large by one
        send_req(mk_alloc(32'hFFFF_FFFF));    // too large, all ones
        send_req(mk_alloc(32'd1025));         // takes the last 2048-byte block
        send_req(mk_alloc(32'd2000));         // largest class now exhausted
        send_req(mk_free(8'd7, 8'd1));        // good free
        send_req(mk_free(8'd7, 8'd1));        // same block again: double free
        send_req(mk_free(8'd7, 8'd2));        // index past the class
        send_req(mk_free(8'd8, 8'd0));        // first class number out of range
        send_req(mk_free(8'hFF, 8'hFF));      // all ones handle
        send_req(mk_free(8'd0, 8'd255));      // valid index never handed out
        send_req(mk_free(8'd1, 8'd128));      // index past class 1
        send_req(mk_free(8'd0, 8'd0));        // good free of class 0 head
        send_req(mk_alloc(32'd8));            // must come back as index 0
        send_req(mk_alloc(32'd1024));
        send_req(mk_alloc(32'd512));
        send_req(mk_alloc(32'd256));
        send_req(mk_alloc(32'd128));
        send_req(mk_alloc(32'd64));
        send_req(mk_alloc(32'd32));

        // random: mostly well-formed allocate/free traffic, some noise
        for (int n = 0; n < N_RANDOM; n++) begin
            idle_stage = (n * 3) / N_RANDOM;
            // first third fills the pool, second drains it, last mixes
            alloc_pct = (idle_stage == 0) ? 80 : (idle_stage == 1) ? 35 : 55;
            free_pct  = 90 - alloc_pct;
            dice = $urandom_range(99);
            if (dice < alloc_pct) begin
                // class 0 gets extra weight so its long list is walked too
                c = ($urandom_range(2) == 0) ? 0 : $urandom_range(N_CLS - 1);
                send_req(mk_alloc(size_in_class(c)));
            end else if (dice < alloc_pct + free_pct && held_q.size() != 0) begin
                h = held_q[$urandom_range(held_q.size() - 1)];
                send_req(mk_free({5'd0, h.cls}, h.idx));
            end else begin
                case ($urandom_range(4))
                    0: send_req(mk_alloc(32'd0));
                    1: send_req(mk_alloc(32'($urandom_range(32'hFFFF_FFFF, 2049))));
                    2: send_req(mk_free(8'($urandom), 8'($urandom)));
                    3: send_req(mk_free(8'($urandom_range(N_CLS - 1)), 8'($urandom)));
                    default: send_req(mk_alloc($urandom));
                endcase
            end
        end

        // wait for the last transfer and every result, then a short drain
        do @(negedge aclk);
        while (req_q.size() != 0 || s_tvalid || resp_due_q.size() != 0);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (err_cnt == 0 && resp_due_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
